FILE: src/pdme_pkg.sv
// ----------------------------------------------------------------------------
// pdme_pkg
// Shared types, constants and helpers of the piecewise delay model evaluator.
// ----------------------------------------------------------------------------
package pdme_pkg;

	localparam int SEGMENTS  = 64;
	localparam int MAX_TERMS = 6;
	localparam int SEG_W     = $clog2(SEGMENTS);
	localparam int TERM_W    = 3;
	localparam int PSEL_W    = 2;
	localparam int NRES      = 5;
	localparam int CA_W      = SEG_W + PSEL_W + TERM_W;

	// one day in 2^-16 s ticks
	localparam logic signed [34:0] DAY_TICKS = 35'sd5662310400;

	localparam logic [1:0] CMD_HDR   = 2'd0;
	localparam logic [1:0] CMD_COEF  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic [1:0]         cmd;
		logic [SEG_W-1:0]   seg_index;
		logic [PSEL_W-1:0]  poly_select;
		logic [TERM_W-1:0]  term_index;
		logic signed [63:0] coeff_value;
		logic [17:0]        day;
		logic [32:0]        time_in_day;
		logic [15:0]        duration_s;
		logic [2:0]         poly_order;
		logic [5:0]         antenna;
		logic [9:0]         source;
		logic               any_source;
	} item_t;

	// k * c with saturation to the signed 64-bit range, k up to 7
	function automatic logic signed [63:0] sat_weight(input logic signed [63:0] c,
		input logic [2:0] k);
		logic signed [67:0] p;
		p = c * $signed({1'b0, k});
		if (p > 68'sd9223372036854775807)
			return S64_MAX;
		else if (p < -68'sd9223372036854775808)
			return S64_MIN;
		else
			return p[63:0];
	endfunction

endpackage

FILE: src/pdme_front.sv
// ----------------------------------------------------------------------------
// pdme_front
// Input side: takes transactions, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
module pdme_front import pdme_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	input  logic  q_ready,
	output item_t q_item
);

	item_t      fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       keep, push, pop;

	// unused command and out-of-range terms change nothing
	assign keep = (in_item.cmd == CMD_HDR) || (in_item.cmd == CMD_QUERY) ||
		((in_item.cmd == CMD_COEF) && (in_item.term_index < TERM_W'(MAX_TERMS)));

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: src/pdme_back.sv
// ----------------------------------------------------------------------------
// pdme_back
// Segment table, sequential search and shared Horner multiply-add unit.
// ----------------------------------------------------------------------------
module pdme_back import pdme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  item_t              q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic signed [63:0] delay_us,
	output logic signed [63:0] rate_us_per_s,
	output logic signed [63:0] u_m,
	output logic signed [63:0] v_m,
	output logic signed [63:0] w_m
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_C1    = 4'd2;
	localparam logic [3:0] ST_C2    = 4'd3;
	localparam logic [3:0] ST_SETUP = 4'd4;
	localparam logic [3:0] ST_LD    = 4'd5;
	localparam logic [3:0] ST_INIT  = 4'd6;
	localparam logic [3:0] ST_M1    = 4'd7;
	localparam logic [3:0] ST_M2    = 4'd8;
	localparam logic [3:0] ST_M3    = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]          state_q;
	logic [SEGMENTS-1:0] valid_q;
	logic [SEG_W-1:0]    scan_q;
	item_t               qry_q;

	logic [50:0]        seg_time_mem [SEGMENTS];
	logic [34:0]        seg_meta_mem [SEGMENTS];
	logic signed [63:0] coef_mem     [2**CA_W];
	logic [50:0]        time_rd_q;
	logic [34:0]        meta_rd_q;
	logic signed [63:0] coef_rd_q;

	logic               match_q;
	logic signed [55:0] dprod_q;
	logic signed [33:0] tdiff_q;
	logic [15:0]        dur_q;
	logic [2:0]         nm1_q, nm1_c1_q;
	logic [31:0]        x_q;
	logic [2:0]         poly_q, term_q;
	logic signed [63:0] y_q, wc_q;
	logic               neg_q, found_q;
	logic [63:0]        mag_q, lo_q, hi_q;
	logic signed [63:0] res_q [NRES];

	logic               is_deriv;
	logic [2:0]         low_term, kfac;
	logic [PSEL_W-1:0]  psel;
	logic [CA_W-1:0]    coef_addr;
	logic               wr_hdr, wr_coef;
	logic signed [18:0] daydiff;
	logic signed [55:0] off;
	logic               hit;
	logic [2:0]         ord_c;
	logic [63:0]        mag;
	logic [64:0]        qsum, qneg;
	logic signed [63:0] mprod;
	logic signed [64:0] ysum;
	logic signed [63:0] ynext;

	assign is_deriv  = (poly_q == 3'd1);
	assign low_term  = is_deriv ? 3'd1 : 3'd0;
	assign kfac      = is_deriv ? term_q : 3'd1;
	assign psel      = (poly_q == 3'd0) ? '0 : PSEL_W'(poly_q - 3'd1);
	assign coef_addr = {scan_q, psel, term_q};

	assign q_ready = (state_q == ST_IDLE);
	assign wr_hdr  = q_valid && q_ready && (q_item.cmd == CMD_HDR);
	assign wr_coef = q_valid && q_ready && (q_item.cmd == CMD_COEF);

	always_ff @(posedge clk) begin
		if (wr_hdr) begin
			seg_time_mem[q_item.seg_index] <= {q_item.day, q_item.time_in_day};
			seg_meta_mem[q_item.seg_index] <= {q_item.duration_s, q_item.poly_order,
				q_item.antenna, q_item.source};
		end
		time_rd_q <= seg_time_mem[scan_q];
		meta_rd_q <= seg_meta_mem[scan_q];
	end

	always_ff @(posedge clk) begin
		if (wr_coef)
			coef_mem[{q_item.seg_index, q_item.poly_select, q_item.term_index}] <=
				q_item.coeff_value;
		coef_rd_q <= coef_mem[coef_addr];
	end

	// window test on the exact offset
	assign daydiff = $signed({1'b0, qry_q.day}) - $signed({1'b0, time_rd_q[50:33]});
	assign off     = dprod_q + 56'(tdiff_q);
	assign hit     = match_q && !off[55] && (off <= $signed({24'd0, dur_q, 16'd0}));
	assign ord_c   = (meta_rd_q[18:16] > 3'(MAX_TERMS - 1)) ? 3'(MAX_TERMS - 1)
		: meta_rd_q[18:16];

	// floor(y * x / 2^16) with saturation, then saturating add of the term
	assign mag  = y_q[63] ? (64'd0 - y_q) : y_q;
	assign qsum = {1'b0, hi_q[47:0], 16'd0} + {17'd0, lo_q[63:16]};
	assign qneg = qsum + {64'd0, (lo_q[15:0] != 16'd0)};
	always_comb begin
		if (hi_q[63:47] != '0)
			mprod = neg_q ? S64_MIN : S64_MAX;
		else if (!neg_q)
			mprod = (qsum > 65'h7FFFFFFFFFFFFFFF) ? S64_MAX : qsum[63:0];
		else if (qneg >= 65'h08000000000000000)
			mprod = S64_MIN;
		else
			mprod = 64'd0 - qneg[63:0];
	end
	assign ysum = 65'(mprod) + 65'(wc_q);
	assign ynext = (ysum > 65'sh0_7FFFFFFFFFFFFFFF) ? S64_MAX
		: (ysum < -65'sh0_8000000000000000) ? S64_MIN : ysum[63:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.cmd == CMD_QUERY)
					qry_q <= q_item;
			end
			ST_C1: begin
				match_q  <= valid_q[scan_q] && (meta_rd_q[15:10] == qry_q.antenna) &&
					(qry_q.any_source || (meta_rd_q[9:0] == qry_q.source));
				dprod_q  <= 56'(daydiff) * 56'(DAY_TICKS);
				tdiff_q  <= $signed({1'b0, qry_q.time_in_day}) -
					$signed({1'b0, time_rd_q[32:0]});
				dur_q    <= meta_rd_q[34:19];
				nm1_c1_q <= ord_c;
			end
			ST_C2: begin
				x_q   <= off[31:0];
				nm1_q <= nm1_c1_q;
			end
			ST_SETUP: begin
				term_q <= nm1_q;
				if (is_deriv && nm1_q == 3'd0)
					y_q <= '0;
			end
			ST_INIT: begin
				y_q <= sat_weight(coef_rd_q, kfac);
				if (term_q != low_term)
					term_q <= term_q - 3'd1;
			end
			ST_M1: begin
				neg_q <= y_q[63];
				mag_q <= mag;
				lo_q  <= {32'd0, mag[31:0]} * {32'd0, x_q};
			end
			ST_M2: begin
				hi_q <= {32'd0, mag_q[63:32]} * {32'd0, x_q};
				wc_q <= sat_weight(coef_rd_q, kfac);
			end
			ST_M3: begin
				y_q <= ynext;
				if (term_q != low_term)
					term_q <= term_q - 3'd1;
			end
			ST_FIN: res_q[poly_q] <= y_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			scan_q    <= '0;
			poly_q    <= '0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (wr_hdr)
						valid_q[q_item.seg_index] <= 1'b1;
					if (q_valid && q_item.cmd == CMD_QUERY) begin
						scan_q  <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: begin
					if (hit) begin
						found_q <= 1'b1;
						poly_q  <= '0;
						state_q <= ST_SETUP;
					end else if (scan_q == SEG_W'(SEGMENTS - 1)) begin
						found_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SETUP: state_q <= (is_deriv && nm1_q == 3'd0) ? ST_FIN : ST_LD;
				ST_LD:    state_q <= ST_INIT;
				ST_INIT:  state_q <= (term_q == low_term) ? ST_FIN : ST_M1;
				ST_M1:    state_q <= ST_M2;
				ST_M2:    state_q <= ST_M3;
				ST_M3:    state_q <= (term_q == low_term) ? ST_FIN : ST_M1;
				ST_FIN: begin
					if (poly_q == 3'(NRES - 1))
						state_q <= ST_OUT;
					else begin
						poly_q  <= poly_q + 3'd1;
						state_q <= ST_SETUP;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			found         <= found_q;
			delay_us      <= found_q ? res_q[0] : '0;
			rate_us_per_s <= found_q ? res_q[1] : '0;
			u_m           <= found_q ? res_q[2] : '0;
			v_m           <= found_q ? res_q[3] : '0;
			w_m           <= found_q ? res_q[4] : '0;
		end
	end

endmodule

FILE: src/piecewise_delay_model_evaluator_top.sv
// ----------------------------------------------------------------------------
// piecewise_delay_model_evaluator_top
// Segment table of polynomial delay models with query by antenna and time.
// ----------------------------------------------------------------------------
// Channel | Handshake           | Carries
// in      | in_valid / in_ready | header write, coefficient write or query
// out     | out_valid/out_ready | one result per query
//
// A query searches the segments in order (up to 64, one table read port), then
// evaluates the five polynomials by Horner steps on the shared multiply unit.
// Reset clears the valid bits and the queues; the tables keep old contents.
// A two-entry queue lets the front take items while the back end works or the
// result register waits to be taken.
// ----------------------------------------------------------------------------
module piecewise_delay_model_evaluator_top import pdme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [5:0]         seg_index,
	input  logic [1:0]         poly_select,
	input  logic [2:0]         term_index,
	input  logic signed [63:0] coeff_value,
	input  logic [17:0]        day,
	input  logic [32:0]        time_in_day,
	input  logic [15:0]        duration_s,
	input  logic [2:0]         poly_order,
	input  logic [5:0]         antenna,
	input  logic [9:0]         source,
	input  logic               any_source,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic signed [63:0] delay_us,
	output logic signed [63:0] rate_us_per_s,
	output logic signed [63:0] u_m,
	output logic signed [63:0] v_m,
	output logic signed [63:0] w_m
);

	item_t in_item, q_item;
	logic  q_valid, q_ready;

	// bundle the transaction fields
	assign in_item = '{cmd: command, seg_index: seg_index, poly_select: poly_select,
		term_index: term_index, coeff_value: coeff_value, day: day,
		time_in_day: time_in_day, duration_s: duration_s, poly_order: poly_order,
		antenna: antenna, source: source, any_source: any_source};

	pdme_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	pdme_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.delay_us      (delay_us),
		.rate_us_per_s (rate_us_per_s),
		.u_m           (u_m),
		.v_m           (v_m),
		.w_m           (w_m)
	);

endmodule

FILE: src/pdme_checker.sv
// ----------------------------------------------------------------------------
// pdme_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pdme_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               found,
	input logic signed [63:0] delay_us,
	input logic signed [63:0] rate_us_per_s,
	input logic signed [63:0] u_m,
	input logic signed [63:0] v_m,
	input logic signed [63:0] w_m
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(delay_us) && $stable(found))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> delay_us == 64'sd0 && rate_us_per_s == 64'sd0 &&
			u_m == 64'sd0 && v_m == 64'sd0 && w_m == 64'sd0)
		else $error("not-found result carries data");

	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_ready)
		else $error("bad state in reset");

endmodule

bind piecewise_delay_model_evaluator_top pdme_checker u_pdme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found         (found),
	.delay_us      (delay_us),
	.rate_us_per_s (rate_us_per_s),
	.u_m           (u_m),
	.v_m           (v_m),
	.w_m           (w_m)
);

FILE: test/piecewise_delay_model_evaluator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_delay_model_evaluator_top_tb
// Self-checking bench for the segment table and the polynomial evaluator.
// Header, coefficient and query transactions are sent through the input
// channel. A predictor inside the bench keeps its own copy of the segment
// table, so every query result (found flag, delay, rate, u, v, w) is checked
// field by field, in order, against the predicted value.
// ----------------------------------------------------------------------------
module piecewise_delay_model_evaluator_top_tb;
	import pdme_pkg::*;

	localparam int  WATCHDOG_LIMIT = 6000;
	localparam int  DRAIN_CYCLES   = 400;
	localparam int  RANDOM_ITEMS   = 1000;
	localparam longint TICKS_DAY   = 64'd5662310400;

	typedef struct {
		logic               found;
		logic signed [63:0] val[5];
	} eval_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	item_t drv = '0;
	logic found;
	logic signed [63:0] delay_us, rate_us_per_s, u_m, v_m, w_m;

	// bench-side copy of the segment table
	bit                 tbl_valid[SEGMENTS];
	bit                 tbl_primed[SEGMENTS];
	logic [17:0]        tbl_day[SEGMENTS];
	logic [32:0]        tbl_tod[SEGMENTS];
	logic [15:0]        tbl_dur[SEGMENTS];
	logic [2:0]         tbl_ord[SEGMENTS];
	logic [5:0]         tbl_ant[SEGMENTS];
	logic [9:0]         tbl_src[SEGMENTS];
	logic signed [63:0] tbl_coef[SEGMENTS][4][MAX_TERMS];

	eval_res_t pending_results[$];
	int        n_errors = 0;
	int        n_sent = 0;
	int        stall_left = 0;
	bit        calm = 1'b0;
	int        quiet = 0;

	always #5 clk = ~clk;

	piecewise_delay_model_evaluator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(drv.cmd), .seg_index(drv.seg_index), .poly_select(drv.poly_select),
		.term_index(drv.term_index), .coeff_value(drv.coeff_value), .day(drv.day),
		.time_in_day(drv.time_in_day), .duration_s(drv.duration_s),
		.poly_order(drv.poly_order), .antenna(drv.antenna), .source(drv.source),
		.any_source(drv.any_source),
		.out_valid(out_valid), .out_ready(out_ready), .found(found),
		.delay_us(delay_us), .rate_us_per_s(rate_us_per_s),
		.u_m(u_m), .v_m(v_m), .w_m(w_m)
	);

	// ------------------------------------------------------------------
	// Fixed-point arithmetic of the evaluator
	// ------------------------------------------------------------------
	function automatic logic signed [63:0] add_clip(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = a + b;
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
		return s[63:0];
	endfunction

	// floor(y * x / 2^16), clipped
	function automatic logic signed [63:0] scale_by_offset(logic signed [63:0] y,
		logic [31:0] x);
		logic signed [96:0] p;
		p = y * $signed({1'b0, x});
		p = p >>> 16;
		if (p > 97'sh7FFF_FFFF_FFFF_FFFF) return S64_MAX;
		if (p < -97'sh8000_0000_0000_0000) return S64_MIN;
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] horner_value(int s, int p, int n,
		logic [31:0] x);
		logic signed [63:0] y;
		y = tbl_coef[s][p][n-1];
		for (int i = n - 2; i >= 0; i--)
			y = add_clip(scale_by_offset(y, x), tbl_coef[s][p][i]);
		return y;
	endfunction

	// i * c[i] built by repeated clipped addition
	function automatic logic signed [63:0] term_weight(logic signed [63:0] c, int k);
		logic signed [63:0] acc;
		acc = '0;
		for (int i = 0; i < k; i++)
			acc = add_clip(acc, c);
		return acc;
	endfunction

	function automatic logic signed [63:0] horner_slope(int s, int n, logic [31:0] x);
		logic signed [63:0] y;
		if (n < 2) return '0;
		y = term_weight(tbl_coef[s][0][n-1], n - 1);
		for (int i = n - 2; i >= 1; i--)
			y = add_clip(scale_by_offset(y, x), term_weight(tbl_coef[s][0][i], i));
		return y;
	endfunction

	// ------------------------------------------------------------------
	// Predictor: applies one accepted transaction to the table copy
	// ------------------------------------------------------------------
	function automatic void track_txn(item_t it);
		eval_res_t r;
		longint off;
		int n;
		case (it.cmd)
			CMD_HDR: begin
				tbl_valid[it.seg_index] = 1'b1;
				tbl_day[it.seg_index] = it.day;
				tbl_tod[it.seg_index] = it.time_in_day;
				tbl_dur[it.seg_index] = it.duration_s;
				tbl_ord[it.seg_index] = it.poly_order;
				tbl_ant[it.seg_index] = it.antenna;
				tbl_src[it.seg_index] = it.source;
			end
			CMD_COEF: begin
				if (it.term_index < MAX_TERMS)
					tbl_coef[it.seg_index][it.poly_select][it.term_index] = it.coeff_value;
			end
			CMD_QUERY: begin
				r.found = 1'b0;
				foreach (r.val[k]) r.val[k] = '0;
				for (int s = 0; s < SEGMENTS; s++) begin
					if (!tbl_valid[s] || tbl_ant[s] != it.antenna) continue;
					if (!it.any_source && tbl_src[s] != it.source) continue;
					off = (longint'(it.day) - longint'(tbl_day[s])) * TICKS_DAY
						+ (longint'(it.time_in_day) - longint'(tbl_tod[s]));
					if (off < 0 || off > longint'(tbl_dur[s]) * 65536) continue;
					n = (tbl_ord[s] > MAX_TERMS - 1) ? MAX_TERMS : tbl_ord[s] + 1;
					r.found = 1'b1;
					r.val[0] = horner_value(s, 0, n, off[31:0]);
					r.val[1] = horner_slope(s, n, off[31:0]);
					for (int p = 1; p < 4; p++)
						r.val[p+1] = horner_value(s, p, n, off[31:0]);
					break;
				end
				pending_results.push_back(r);
			end
			default: ;	// unused command: no effect
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender: one transaction, entered and left at a falling edge
	// ------------------------------------------------------------------
	task automatic push_txn(item_t it);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		drv = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		track_txn(it);
		n_sent++;
		@(negedge clk);
	endtask

	// ignored fields carry random bits so every input bit toggles
	function automatic item_t noise_item();
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic logic signed [63:0] pick_coef();
		case ($urandom_range(9))
			0: return S64_MAX;
			1: return S64_MIN;
			2, 3: return {$urandom, $urandom};
			default: return 64'(signed'({$urandom_range(255), $urandom}));
		endcase
	endfunction

	task automatic write_coef(int s, int p, int t, logic signed [63:0] c);
		item_t it;
		it = noise_item();
		it.cmd = CMD_COEF;
		it.seg_index = SEG_W'(s);
		it.poly_select = PSEL_W'(p);
		it.term_index = TERM_W'(t);
		it.coeff_value = c;
		push_txn(it);
	endtask

	// every coefficient of a slot is written before the slot first goes valid
	task automatic prime_slot(int s);
		for (int p = 0; p < 4; p++)
			for (int t = 0; t < MAX_TERMS; t++)
				write_coef(s, p, t, pick_coef());
		tbl_primed[s] = 1'b1;
	endtask

	task automatic write_header(int s, logic [17:0] d, logic [32:0] tod,
		logic [15:0] dur, logic [2:0] ord, logic [5:0] ant, logic [9:0] src);
		item_t it;
		if (!tbl_primed[s]) prime_slot(s);
		it = noise_item();
		it.cmd = CMD_HDR;
		it.seg_index = SEG_W'(s);
		it.day = d;
		it.time_in_day = tod;
		it.duration_s = dur;
		it.poly_order = ord;
		it.antenna = ant;
		it.source = src;
		push_txn(it);
	endtask

	task automatic query_raw(logic [17:0] d, logic [32:0] tod, logic [5:0] ant,
		logic [9:0] src, logic anysrc);
		item_t it;
		it = noise_item();
		it.cmd = CMD_QUERY;
		it.day = d;
		it.time_in_day = tod;
		it.antenna = ant;
		it.source = src;
		it.any_source = anysrc;
		push_txn(it);
	endtask

	// query at a given offset into slot s; a wildcard query uses another source
	task automatic query_at(int s, longint off, logic anysrc);
		longint total, base;
		logic [17:0] d;
		logic [32:0] tod;
		logic [9:0] src;
		base = longint'(tbl_day[s]) * TICKS_DAY;
		total = base + longint'(tbl_tod[s]) + off;
		if (total < 0) total = base + longint'(tbl_tod[s]);
		if ($urandom_range(1) && total - base >= 0 && total - base < 64'd8589934592) begin
			d = tbl_day[s];
			tod = 33'(total - base);
		end else if (total / TICKS_DAY < 262144) begin
			d = 18'(total / TICKS_DAY);
			tod = 33'(total % TICKS_DAY);
		end else begin
			d = tbl_day[s];
			tod = tbl_tod[s];
		end
		src = anysrc ? tbl_src[s] ^ 10'($urandom_range(1023, 1)) : tbl_src[s];
		query_raw(d, tod, tbl_ant[s], src, anysrc);
	endtask

	function automatic longint pick_offset(int s);
		longint span;
		span = longint'(tbl_dur[s]) * 65536;
		case ($urandom_range(9))
			0: return -1;
			1: return span + 1;
			2: return 0;
			3: return span;
			default: return longint'($urandom) % (span + 1);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random ready, long forced hold-offs on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready = calm || ($urandom_range(99) >= 36);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: in-order compare against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		eval_res_t want;
		logic signed [63:0] got[5];
		string fname[5];
		if (out_valid && out_ready) begin
			got = '{delay_us, rate_us_per_s, u_m, v_m, w_m};
			fname = '{"delay_us", "rate_us_per_s", "u_m", "v_m", "w_m"};
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want.found, found);
					n_errors++;
				end
				for (int k = 0; k < 5; k++)
					if (got[k] !== want.val[k]) begin
						$display("%0t: %s expected %0d actual %0d", $time, fname[k],
							want.val[k], got[k]);
						n_errors++;
					end
			end
		end
	end

	// watchdog: cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_empty_table();
		query_raw(18'h3FFFF, 33'h1_FFFF_FFFF, 6'd63, 10'd1023, 1'b1);
		query_raw('0, '0, '0, '0, 1'b0);
	endtask

	// header fields at their extremes; query right at the window end
	task automatic test_extremes();
		write_header(0, 18'd262142, 33'(TICKS_DAY - 1), 16'hFFFF, 3'd7, 6'd63, 10'd1023);
		query_at(0, longint'(16'hFFFF) * 65536, 1'b0);
		query_at(0, 0, 1'b1);
		query_at(0, longint'(16'hFFFF) * 65536 + 1, 1'b0);
	endtask

	task automatic test_special_cases();
		item_t it;
		// order zero: constants only, no rate
		write_header(1, 18'd60000, 33'd1000, 16'd100, 3'd0, 6'd1, 10'd5);
		query_at(1, 12345, 1'b0);
		// term index past the table is dropped
		write_coef(1, 0, 6, S64_MAX);
		write_coef(1, 3, 7, S64_MIN);
		// header rewrite keeps coefficients, now with a real order
		write_header(1, 18'd60000, 33'd1000, 16'd100, 3'd3, 6'd1, 10'd5);
		// a later slot overlaps, the lower slot must win
		write_header(2, 18'd60000, 33'd0, 16'd200, 3'd5, 6'd1, 10'd5);
		query_at(1, 50 * 65536, 1'b0);
		query_at(1, -1, 1'b0);
		// time of day past one day, used as it stands
		write_header(3, 18'd70000, 33'h1_FFFF_0000, 16'd1, 3'd2, 6'd2, 10'd7);
		query_raw(18'd70000, 33'h1_FFFF_FFFF, 6'd2, 10'd7, 1'b0);
		query_raw(18'd70001, 33'h1_FFFF_FFFF - 33'(TICKS_DAY), 6'd2, 10'd9, 1'b1);
		// unused command gives nothing
		it = noise_item();
		it.cmd = 2'd3;
		push_txn(it);
	endtask

	// receiver holds off while queries keep coming, so the queue fills
	task automatic test_backpressure();
		stall_left = 700;
		for (int i = 0; i < 10; i++)
			query_at(1 + (i % 2), pick_offset(1), 1'b0);
	endtask

	task automatic test_random();
		int s, start;
		start = n_sent;
		while (n_sent - start < RANDOM_ITEMS) begin
			calm = (n_sent - start > 400 && n_sent - start < 550);
			s = $urandom_range(SEGMENTS - 1);
			case ($urandom_range(99)) inside
				[0:11]: write_header(s,
					($urandom_range(9) == 0) ? 18'($urandom) : 18'(60000 + $urandom_range(3)),
					($urandom_range(9) == 0) ? 33'({$urandom, $urandom})
						: ({1'b0, $urandom_range(32'd2831155199)} << 1),
					($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600, 1)),
					3'($urandom_range(7)),
					($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(3)),
					($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(3)));
				[12:41]: begin
					if (!tbl_primed[s]) prime_slot(s);
					write_coef(s, $urandom_range(3), $urandom_range(7), pick_coef());
				end
				[42:94]: begin
					if (!tbl_valid[s]) s = 1;
					if ($urandom_range(9) == 0)
						query_raw(18'($urandom), 33'({$urandom, $urandom}),
							6'($urandom_range(3)), 10'($urandom_range(3)), 1'($urandom));
					else
						query_at(s, pick_offset(s), $urandom_range(3) == 0);
				end
				default: begin
					item_t it;
					it = noise_item();
					it.cmd = 2'd3;
					push_txn(it);
				end
			endcase
		end
		calm = 1'b0;
	endtask

	initial begin
		#1 arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_table();
		test_extremes();
		test_special_cases();
		test_backpressure();
		test_random();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/pdme_pkg.sv
src/pdme_front.sv
src/pdme_back.sv
src/piecewise_delay_model_evaluator_top.sv
src/pdme_checker.sv
test/piecewise_delay_model_evaluator_top_tb.sv
